// ===== rtl/block_table_heap_allocator_macros.svh =====
// Assertion macros shared by the checker of the block table heap allocator.
// Depends on nothing; expects i_clk and i_rst_n in the scope of use.
`ifndef BLOCK_TABLE_HEAP_ALLOCATOR_MACROS_SVH
`define BLOCK_TABLE_HEAP_ALLOCATOR_MACROS_SVH

// same-cycle implication, off during reset
`define BTHA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define BTHA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/btha_pkg.sv =====
// Package for the block table heap allocator: word types, table entry,
// controller states and codes. No dependencies.
package btha_pkg;

    localparam logic       KIND_ALLOC = 1'b0;
    localparam logic       KIND_FREE  = 1'b1;

    localparam logic       STATUS_OK    = 1'b0;
    localparam logic       STATUS_NOMEM = 1'b1;

    localparam logic [0:0] CFG_BASE_ADDRESS  = 1'b0;
    localparam logic [0:0] CFG_BLOCKS_IN_USE = 1'b1;

    localparam logic [31:0] BASE_ADDRESS_RST  = 32'h0100_0000;
    localparam logic [10:0] BLOCKS_IN_USE_RST = 11'd1024;

    typedef struct packed {
        logic        kind;
        logic [31:0] size_bytes;
        logic [31:0] release_address;
    } t_in_word;

    typedef struct packed {
        logic [31:0] granted_address;
        logic        status;
    } t_out_word;

    // one table entry
    typedef struct packed {
        logic has_next;
        logic first;
        logic taken;
    } t_entry;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_SCAN,
        ST_MARK,
        ST_ADDR,
        ST_FREE,
        ST_RESP
    } t_state;

endpackage

// ===== rtl/btha_div.sv =====
// Division by a constant divisor: reciprocal multiply, saturated at a limit.
// Start loads the operands, then the product and done are registered. Depends on nothing.
module btha_div #(
    parameter int DIVISOR = 4096,
    parameter int MAX_Q   = 1025,
    parameter int LW      = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [32:0]   i_dividend,
    input  logic [LW-1:0] i_limit,
    output logic          o_done,
    output logic [32:0]   o_quotient
);

    // below limit * DIVISOR the dividend fits N bits; with K = N + ceil(log2 DIVISOR)
    // and RECIP = ceil(2^K / DIVISOR) the product shifted by K is the exact floor
    localparam int N  = $clog2(longint'(MAX_Q) * longint'(DIVISOR));
    localparam int L  = $clog2(DIVISOR);
    localparam int K  = N + L;
    localparam int MW = N + 1;
    localparam int PW = N + MW;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << K) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
    localparam logic [33:0]   DIV_K = 34'(DIVISOR);

    logic [32:0]   r_x;
    logic [LW-1:0] r_lim;
    logic          r_step;
    logic          r_done;
    logic          r_over;
    logic [PW-1:0] r_prod;
    logic [33:0]   w_cap;

    assign w_cap = 34'(r_lim) * DIV_K;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_step <= i_start;
            r_done <= r_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_dividend;
            r_lim <= i_limit;
        end
        if (r_step) begin
            r_over <= ({1'b0, r_x} >= w_cap);
            r_prod <= PW'(r_x[N-1:0]) * PW'(RECIP);
        end
    end

    // at or above the cap the quotient saturates at the limit
    assign o_done     = r_done;
    assign o_quotient = r_over ? 33'(r_lim) : 33'(r_prod >> K);

endmodule

// ===== rtl/btha_table_mem.sv =====
// Block table storage: one write port, one read port, registered read data.
// Depends on btha_pkg.
module btha_table_mem #(
    parameter int DEPTH = 1024,
    parameter int IW    = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [IW-1:0]     i_waddr,
    input  btha_pkg::t_entry  i_wdata,
    input  logic [IW-1:0]     i_raddr,
    output btha_pkg::t_entry  o_rdata
);

    btha_pkg::t_entry r_mem [DEPTH];
    btha_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/block_table_heap_allocator.sv =====
// First-fit block allocator, one word at a time. Allocate: divide, check, scan, mark,
// form the address, answer; zero or oversize fails at the check, a scan reaching the pool
// end short of a run fails too. Free: divide, clear along the has-next chain, answer; an
// index past the pool is ignored. A stalled result holds the controller at the next
// answer. Reset: synchronous, active low, then a clearing pass over all entries, input
// ready low (config writes are taken). Depends on btha_pkg, btha_div, btha_table_mem.
module block_table_heap_allocator #(
    parameter int MAX_BLOCKS = 1024,
    parameter int BLOCK_SIZE = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  btha_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output btha_pkg::t_out_word o_out_word,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_wdata
);

    // IW indexes the table, CW counts up to MAX_BLOCKS, LW up to MAX_BLOCKS + 1
    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int LW = $clog2(MAX_BLOCKS + 2);
    localparam logic [IW-1:0] LAST_IDX   = IW'(MAX_BLOCKS - 1);
    localparam logic [31:0]   BS_W       = 32'(BLOCK_SIZE);
    localparam logic [32:0]   BS_ROUND   = 33'(BLOCK_SIZE - 1);
    localparam logic [31:0]   MAXB_W     = 32'(MAX_BLOCKS);

    // configuration registers
    logic [31:0] r_base;
    logic [10:0] r_blocks;

    // controller
    btha_pkg::t_state    r_state, n_state;
    logic                r_kind;
    logic [IW-1:0]       r_chk, n_chk;
    logic [IW-1:0]       r_start, n_start;
    logic [CW-1:0]       r_run, n_run;
    logic [CW-1:0]       r_need, n_need;
    logic [CW-1:0]       r_wk, n_wk;
    logic [31:0]         r_prod;
    btha_pkg::t_out_word r_res, n_res;
    logic                r_out_valid;
    btha_pkg::t_out_word r_out;

    // datapath wires
    logic [CW-1:0]    w_total;
    logic [32:0]      w_total_q;
    logic [LW-1:0]    w_limit;
    logic             w_accept;
    logic             w_div_done;
    logic [32:0]      w_quot;
    logic [32:0]      w_dividend;
    logic             w_we;
    logic [IW-1:0]    w_waddr;
    logic [IW-1:0]    w_raddr;
    btha_pkg::t_entry w_wdata;
    btha_pkg::t_entry w_rdata;
    logic [CW-1:0]    w_chk_nx;
    logic             w_load_out;

    // pool size = min(blocks_in_use, MAX_BLOCKS)
    assign w_total   = ({21'b0, r_blocks} > MAXB_W) ? CW'(MAX_BLOCKS) : CW'(r_blocks);
    assign w_total_q = 33'(w_total);
    // quotient saturates one past the pool: refused allocation, ignored free
    assign w_limit   = LW'(w_total) + LW'(1);
    assign w_chk_nx  = CW'(r_chk) + CW'(1);

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == btha_pkg::ST_IDLE);

    // alloc: ceil(size / BLOCK_SIZE); free: (addr - base) / BLOCK_SIZE
    assign w_dividend = (i_in_word.kind == btha_pkg::KIND_ALLOC)
                      ? ({1'b0, i_in_word.size_bytes} + BS_ROUND)
                      : {1'b0, i_in_word.release_address - r_base};

    btha_div #(
        .DIVISOR (BLOCK_SIZE),
        .MAX_Q   (MAX_BLOCKS + 1),
        .LW      (LW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_dividend (w_dividend),
        .i_limit    (w_limit),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    btha_table_mem #(
        .DEPTH (MAX_BLOCKS),
        .IW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= btha_pkg::BASE_ADDRESS_RST;
            r_blocks <= btha_pkg::BLOCKS_IN_USE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                btha_pkg::CFG_BASE_ADDRESS:  r_base   <= i_cfg_wdata;
                btha_pkg::CFG_BLOCKS_IN_USE: r_blocks <= i_cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= btha_pkg::ST_CLEAR;
            r_chk   <= '0;
        end else begin
            r_state <= n_state;
            r_chk   <= n_chk;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_in_word.kind;
        end
        r_start <= n_start;
        r_run   <= n_run;
        r_need  <= n_need;
        r_wk    <= n_wk;
        r_res   <= n_res;
        // byte offset of the run; stable by the time ST_ADDR uses it
        r_prod  <= 32'(32'(r_start) * BS_W);
    end

    // output register: a finished result waits here while the next word comes in
    assign w_load_out = (r_state == btha_pkg::ST_RESP) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // next state, table port control
    always_comb begin
        n_state = r_state;
        n_chk   = r_chk;
        n_start = r_start;
        n_run   = r_run;
        n_need  = r_need;
        n_wk    = r_wk;
        n_res   = r_res;
        w_we    = 1'b0;
        w_waddr = r_chk;
        w_wdata = '0;
        // read one ahead of the entry under test
        w_raddr = IW'(w_chk_nx);

        unique case (r_state)
            btha_pkg::ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_chk;
                n_chk   = IW'(w_chk_nx);
                if (r_chk == LAST_IDX) begin
                    n_chk   = '0;
                    n_state = btha_pkg::ST_IDLE;
                end
            end

            btha_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = btha_pkg::ST_DIV;
                end
            end

            btha_pkg::ST_DIV: begin
                w_raddr = w_quot[IW-1:0];
                if (w_div_done) begin
                    if (r_kind == btha_pkg::KIND_ALLOC) begin
                        n_state = btha_pkg::ST_CHECK;
                    end else if (w_quot >= w_total_q) begin
                        // index past the pool: ignored
                        n_res   = '{granted_address: '0, status: btha_pkg::STATUS_OK};
                        n_state = btha_pkg::ST_RESP;
                    end else begin
                        n_chk   = w_quot[IW-1:0];
                        n_state = btha_pkg::ST_FREE;
                    end
                end
            end

            btha_pkg::ST_CHECK: begin
                w_raddr = '0;
                if ((w_quot == '0) || (w_quot > w_total_q)) begin
                    n_res   = '{granted_address: '0, status: btha_pkg::STATUS_NOMEM};
                    n_state = btha_pkg::ST_RESP;
                end else begin
                    n_need  = w_quot[CW-1:0];
                    n_chk   = '0;
                    n_run   = '0;
                    n_state = btha_pkg::ST_SCAN;
                end
            end

            btha_pkg::ST_SCAN: begin
                // w_rdata holds entry r_chk
                if (w_rdata.taken) begin
                    n_run = '0;
                end else begin
                    if (r_run == '0) begin
                        n_start = r_chk;
                    end
                    n_run = r_run + CW'(1);
                end
                if (!w_rdata.taken && ((r_run + CW'(1)) == r_need)) begin
                    n_wk    = '0;
                    n_state = btha_pkg::ST_MARK;
                end else if (w_chk_nx == w_total) begin
                    // end of pool without a full run
                    n_res   = '{granted_address: '0, status: btha_pkg::STATUS_NOMEM};
                    n_state = btha_pkg::ST_RESP;
                end else begin
                    n_chk = IW'(w_chk_nx);
                end
            end

            btha_pkg::ST_MARK: begin
                w_we             = 1'b1;
                w_waddr          = r_start + IW'(r_wk);
                w_wdata.taken    = 1'b1;
                w_wdata.first    = (r_wk == '0);
                w_wdata.has_next = ((r_wk + CW'(1)) < r_need);
                n_wk             = r_wk + CW'(1);
                if ((r_wk + CW'(1)) == r_need) begin
                    n_state = btha_pkg::ST_ADDR;
                end
            end

            btha_pkg::ST_ADDR: begin
                n_res   = '{granted_address: r_base + r_prod, status: btha_pkg::STATUS_OK};
                n_state = btha_pkg::ST_RESP;
            end

            btha_pkg::ST_FREE: begin
                // clear entry r_chk, follow has-next; next entry already being read
                w_we    = 1'b1;
                w_waddr = r_chk;
                if (w_rdata.has_next && (w_chk_nx < w_total)) begin
                    n_chk = IW'(w_chk_nx);
                end else begin
                    n_res   = '{granted_address: '0, status: btha_pkg::STATUS_OK};
                    n_state = btha_pkg::ST_RESP;
                end
            end

            btha_pkg::ST_RESP: begin
                if (w_load_out) begin
                    n_chk   = '0;
                    n_state = btha_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = btha_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/btha_checker.sv =====
// Port-level checker for block_table_heap_allocator, bound to the top level.
// Depends on btha_pkg and block_table_heap_allocator_macros.svh.
`include "block_table_heap_allocator_macros.svh"

module btha_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input btha_pkg::t_out_word o_out_word
);

    `BTHA_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_word), "result word dropped or changed while stalled")
    `BTHA_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "input taken again before the word was done")
    `BTHA_ASSERT_NOW(a_result_when_idle, $rose(o_out_valid), o_in_ready, "result shown without returning to idle")
    `BTHA_ASSERT_NOW(a_fail_zero_addr, o_out_valid && (o_out_word.status == btha_pkg::STATUS_NOMEM), o_out_word.granted_address == 32'd0, "failed result carries an address")

endmodule

bind block_table_heap_allocator btha_checker u_btha_checker (.*);

// ===== verif/block_table_heap_allocator_test.sv =====
// Self-checking testbench for block_table_heap_allocator: drives allocate and free words,
// predicts each result from a shadow block table, and compares results field by field.
// Depends on btha_pkg and the allocator RTL.
`timescale 1ns / 1ps

module block_table_heap_allocator_test;

    localparam int unsigned MAX_BLOCKS  = 1024;
    localparam int unsigned BLOCK_SIZE  = 4096;
    // drain wait after the last word, long enough for the worst word: divide, scan, mark
    localparam int unsigned WORD_CYCLES = 2200;
    // long receiver hold-off used once to back the block up
    localparam int unsigned HOLD_CYCLES = 1500;
    // cycles without any accepted word before the run is declared hung;
    // covers the reset clearing pass, the hold-off and several worst words
    localparam int unsigned STALL_LIMIT = 20000;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    btha_pkg::t_in_word  in_word = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    btha_pkg::t_out_word out_word;
    logic                cfg_we = 1'b0;
    logic [0:0]          cfg_idx = btha_pkg::CFG_BASE_ADDRESS;
    logic [31:0]         cfg_wdata = '0;

    // shadow of the block: its table and its two registers
    btha_pkg::t_entry    shadow_tbl [MAX_BLOCKS];
    logic [31:0]         cfg_base   = btha_pkg::BASE_ADDRESS_RST;
    logic [10:0]         cfg_blocks = btha_pkg::BLOCKS_IN_USE_RST;

    btha_pkg::t_in_word  pending_q [$];     // words waiting for the driver
    btha_pkg::t_out_word grant_q   [$];     // predicted results, oldest first
    int unsigned         live_starts [$];   // start blocks of allocations still held
    btha_pkg::t_out_word oldest;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_request  = 0;
    int unsigned hold_taken    = 0;
    int unsigned hold_left     = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned fails         = 0;
    int unsigned n_grants      = 0;
    int unsigned n_refusals    = 0;
    int unsigned n_frees       = 0;
    int unsigned n_settings    = 0;

    block_table_heap_allocator #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Applies one word to the shadow table and returns the result it must give.
    // First fit: the scan restarts its run at every taken entry and stops at the
    // first run of the needed length; a free walks the has-next chain from the
    // index the address maps to, whatever kind of entry sits there.
    function automatic btha_pkg::t_out_word serve_word(input btha_pkg::t_in_word w);
        btha_pkg::t_out_word res;
        btha_pkg::t_entry    ent;
        logic [32:0]         need;
        int unsigned         total;
        int unsigned         run;
        int unsigned         start;
        int unsigned         idx;
        bit                  found;
        res.granted_address = '0;
        res.status          = btha_pkg::STATUS_OK;
        total = (cfg_blocks > MAX_BLOCKS) ? MAX_BLOCKS : cfg_blocks;
        if (w.kind == btha_pkg::KIND_ALLOC) begin
            need  = ({1'b0, w.size_bytes} + 33'(BLOCK_SIZE - 1)) / 33'(BLOCK_SIZE);
            found = 1'b0;
            run   = 0;
            start = 0;
            // zero size and oversize are refused without a scan
            if (need != 0 && need <= total) begin
                for (int unsigned i = 0; i < total && !found; i++) begin
                    if (shadow_tbl[i].taken) begin
                        run = 0;
                    end else begin
                        if (run == 0) start = i;
                        run++;
                        if (run == need) found = 1'b1;
                    end
                end
            end
            if (found) begin
                for (int unsigned i = 0; i < run; i++) begin
                    shadow_tbl[start + i].taken    = 1'b1;
                    shadow_tbl[start + i].first    = (i == 0);
                    shadow_tbl[start + i].has_next = (i + 1 < run);
                end
                // address wraps modulo 2^32
                res.granted_address = cfg_base + start * BLOCK_SIZE;
                live_starts.push_back(start);
                n_grants++;
            end else begin
                // includes a scan that hits the pool end short of a full run
                res.status = btha_pkg::STATUS_NOMEM;
                n_refusals++;
            end
        end else begin
            // addresses below the base wrap to a huge index and are ignored
            idx = (w.release_address - cfg_base) / BLOCK_SIZE;
            for (int unsigned i = idx; i < total; i++) begin
                ent           = shadow_tbl[i];
                shadow_tbl[i] = '0;
                if (!ent.has_next) break;
            end
            n_frees++;
        end
        return res;
    endfunction

    // Driver: predicts each word as it is accepted and loads the next one
    // in the same step, so valid stays high across back-to-back words.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) grant_q.push_back(serve_word(in_word));
            if (!in_valid || in_ready) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_word  <= pending_q.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request so the block
    // keeps its result and backs up the input side.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_taken != hold_request) begin
            hold_taken <= hold_request;
            hold_left  <= HOLD_CYCLES;
            out_ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: each result word against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (grant_q.size() == 0) begin
                $error("result word with nothing expected: granted_address %h status %b",
                       out_word.granted_address, out_word.status);
                fails++;
            end else begin
                oldest = grant_q.pop_front();
                if (out_word.granted_address !== oldest.granted_address) begin
                    $error("granted_address: expected %h, got %h",
                           oldest.granted_address, out_word.granted_address);
                    fails++;
                end
                if (out_word.status !== oldest.status) begin
                    $error("status: expected %b, got %b", oldest.status, out_word.status);
                    fails++;
                end
            end
        end
    end

    // Watchdog: any accepted word on either side restarts the count.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no word accepted for %0d cycles", STALL_LIMIT);
                $display("block_table_heap_allocator verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Block is idle once nothing is queued, offered or owed.
    task automatic wait_drained();
        while (pending_q.size() != 0 || in_valid || grant_q.size() != 0) @(negedge clk);
    endtask

    // Registers change only between phases, with the block idle; the shadow
    // copy follows once the write has gone in.
    task automatic set_pool(input logic [31:0] base, input logic [10:0] blocks);
        wait_drained();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= btha_pkg::CFG_BASE_ADDRESS;
        cfg_wdata <= base;
        @(posedge clk);
        cfg_idx   <= btha_pkg::CFG_BLOCKS_IN_USE;
        cfg_wdata <= {21'd0, blocks};
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_base   = base;
        cfg_blocks = blocks;
        n_settings++;
        @(negedge clk);
    endtask

    // Directed word: the field the operation ignores gets random content.
    task automatic push_word(input logic kind, input logic [31:0] value);
        btha_pkg::t_in_word w;
        w.kind            = kind;
        w.size_bytes      = (kind == btha_pkg::KIND_ALLOC) ? value : $urandom;
        w.release_address = (kind == btha_pkg::KIND_FREE) ? value : $urandom;
        pending_q.push_back(w);
    endtask

    // Random words, one ahead of the driver so frees can target live grants.
    // Mostly allocations and matching frees; the rest are frees into the middle
    // of chains, past the pool, or anywhere, and odd sizes.
    task automatic run_random(input int unsigned count);
        btha_pkg::t_in_word w;
        int unsigned        pool;
        int unsigned        r;
        int unsigned        k;
        for (int unsigned n = 0; n < count; n++) begin
            while (pending_q.size() != 0) @(negedge clk);
            pool              = (cfg_blocks > MAX_BLOCKS) ? MAX_BLOCKS : cfg_blocks;
            w.kind            = btha_pkg::KIND_ALLOC;
            w.size_bytes      = $urandom;
            w.release_address = $urandom;
            r                 = $urandom_range(99);
            if (r >= 50 && r < 85 && live_starts.size() != 0) begin
                k      = $urandom_range(live_starts.size() - 1);
                w.kind = btha_pkg::KIND_FREE;
                w.release_address = cfg_base + live_starts[k] * BLOCK_SIZE
                    + (($urandom_range(3) == 0) ? $urandom_range(BLOCK_SIZE - 1) : 0);
                live_starts.delete(k);
            end else if (r >= 85) begin
                w.kind = btha_pkg::KIND_FREE;
                if ($urandom_range(1) == 0)
                    w.release_address = cfg_base + $urandom_range(pool + 2) * BLOCK_SIZE;
            end else begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: w.size_bytes = $urandom_range(4 * BLOCK_SIZE, 1);
                    6, 7:             w.size_bytes = $urandom_range(pool * BLOCK_SIZE, 1);
                    8:                w.size_bytes = '0;
                    default: ;        // full 32-bit size, nearly always refused
                endcase
            end
            pending_q.push_back(w);
        end
    endtask

    initial begin
        logic [31:0] b;
        for (int i = 0; i < MAX_BLOCKS; i++) shadow_tbl[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // sender rarely idle, receiver mostly stalled
        send_idle_pct = 7;
        recv_idle_pct = 74;

        // directed, full pool at the reset base
        set_pool(btha_pkg::BASE_ADDRESS_RST, btha_pkg::BLOCKS_IN_USE_RST);
        b = cfg_base;
        push_word(btha_pkg::KIND_ALLOC, 32'd0);                    // zero size refused
        push_word(btha_pkg::KIND_ALLOC, 32'd1);                    // block 0
        push_word(btha_pkg::KIND_ALLOC, BLOCK_SIZE);               // block 1
        push_word(btha_pkg::KIND_ALLOC, BLOCK_SIZE + 1);           // blocks 2-3
        push_word(btha_pkg::KIND_ALLOC, 32'hFFFF_FFFF);            // larger than any pool
        push_word(btha_pkg::KIND_ALLOC, MAX_BLOCKS * BLOCK_SIZE);  // whole pool, no run
        push_word(btha_pkg::KIND_FREE, b + BLOCK_SIZE);
        push_word(btha_pkg::KIND_FREE, b + 2 * BLOCK_SIZE + 5);    // unaligned, frees 2-3
        push_word(btha_pkg::KIND_ALLOC, 3 * BLOCK_SIZE);           // blocks 1-3
        push_word(btha_pkg::KIND_FREE, b + 2 * BLOCK_SIZE);        // from a non-first entry
        push_word(btha_pkg::KIND_FREE, b + BLOCK_SIZE);            // walk stops at a free entry
        push_word(btha_pkg::KIND_FREE, b - 1);                     // below the base
        push_word(btha_pkg::KIND_ALLOC, 1020 * BLOCK_SIZE);        // blocks 1-1020
        push_word(btha_pkg::KIND_ALLOC, 4 * BLOCK_SIZE);           // pool end reached with a run of three
        push_word(btha_pkg::KIND_ALLOC, 3 * BLOCK_SIZE);           // last three, table full
        push_word(btha_pkg::KIND_FREE, b);
        push_word(btha_pkg::KIND_FREE, b + BLOCK_SIZE);            // long chain
        push_word(btha_pkg::KIND_FREE, b + 1021 * BLOCK_SIZE);
        push_word(btha_pkg::KIND_ALLOC, MAX_BLOCKS * BLOCK_SIZE);  // whole pool granted
        push_word(btha_pkg::KIND_FREE, b);                         // chain to the pool end

        // directed, tiny pool whose addresses wrap past 2^32
        set_pool(32'hFFFF_F000, 11'd4);
        push_word(btha_pkg::KIND_ALLOC, 2 * BLOCK_SIZE);
        push_word(btha_pkg::KIND_ALLOC, BLOCK_SIZE);               // wraps to 0x1000
        push_word(btha_pkg::KIND_ALLOC, 2 * BLOCK_SIZE);           // one block left
        push_word(btha_pkg::KIND_FREE, 32'h0000_1000);
        push_word(btha_pkg::KIND_ALLOC, BLOCK_SIZE + 1);
        push_word(btha_pkg::KIND_FREE, 32'h0000_0FFF);             // lands in block 1
        push_word(btha_pkg::KIND_FREE, 32'hFFFF_F000);

        // random phases over a range of bases and pool sizes
        set_pool($urandom, 11'd1024);
        run_random(75);
        set_pool(32'h0000_0000, 11'd64);
        run_random(75);

        // sender mostly idle, receiver rarely
        send_idle_pct = 74;
        recv_idle_pct = 7;
        set_pool($urandom, 11'd1);
        run_random(60);
        set_pool(32'hFFFF_FFFF, 11'd200);
        run_random(80);

        // no idling; one long receiver hold-off at the start
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_pool($urandom, 11'd1024);
        hold_request++;
        run_random(80);
        set_pool($urandom, 11'($urandom_range(1024, 1)));
        run_random(80);

        wait_drained();
        repeat (WORD_CYCLES) @(posedge clk);

        $display("covered %0d words: %0d grants, %0d refusals, %0d frees",
                 n_grants + n_refusals + n_frees, n_grants, n_refusals, n_frees);
        $display("across %0d base and pool settings, pools from 1 to 1024 blocks",
                 n_settings);
        if (fails == 0) begin
            $display("block_table_heap_allocator verification clean");
        end else begin
            $display("block_table_heap_allocator verification failed");
        end
        $finish;
    end

endmodule
